/* rtl/core/sdp_pkg.sv */
// Shared types and constants of the soft symbol depuncturer.
package sdp_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int SIZE_W   = 6;
	localparam int PAT_W    = 32;
	localparam int DELAY_W  = 5;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = 2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_SIZE    = 2'd0;
	localparam logic [1:0] REG_PATTERN = 2'd1;
	localparam logic [1:0] REG_DELAY   = 2'd2;

	// register reset values
	localparam logic [SIZE_W-1:0]  SIZE_RST    = 6'd2;
	localparam logic [PAT_W-1:0]   PATTERN_RST = 32'd3;
	localparam logic [DELAY_W-1:0] DELAY_RST   = 5'd0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// control from the register block to the run generator
	typedef struct packed {
		logic busy;     // effective pattern being rebuilt
		logic restart;  // listed register written: period restarts
	} sdp_ctl_t;

endpackage

/* rtl/core/sdp_regs.sv */
// Configuration registers and the effective pattern setup sequencer.
module sdp_regs #(
	parameter int MAX_PERIOD = 32,
	localparam int CW = $clog2(MAX_PERIOD + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sdp_pkg::PADDR_W-1:0]   paddr,
	input  logic [sdp_pkg::PDATA_W-1:0]   pwdata,
	output logic [sdp_pkg::PDATA_W-1:0]   prdata,
	output logic [MAX_PERIOD-1:0]         eff_pattern,
	output logic [CW-1:0]                 eff_size,
	output sdp_pkg::sdp_ctl_t             ctl
);
	import sdp_pkg::*;

	localparam logic [SIZE_W-1:0] MAXP = SIZE_W'(MAX_PERIOD);

	typedef enum logic [2:0] {
		S_LOAD,
		S_REDUCE,
		S_ROT,
		S_ALIGN,
		S_IDLE
	} setup_state_t;

	setup_state_t         state_q;
	logic [SIZE_W-1:0]    size_q;
	logic [PAT_W-1:0]     pattern_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [DELAY_W-1:0]   r_q;
	logic [CW-1:0]        n_q;
	logic [MAX_PERIOD-1:0] rot_q;
	logic [MAX_PERIOD-1:0] pat_q;

	logic [1:0]           wr_idx;
	logic                 wr_en;
	logic                 restart;
	logic [SIZE_W-1:0]    size_clamped;
	logic [63:0]          mask64;
	logic [63:0]          p64;
	logic [63:0]          rot64;
	logic [6:0]           lshift;

	assign wr_idx  = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign restart = wr_en && (wr_idx == REG_SIZE || wr_idx == REG_PATTERN ||
		wr_idx == REG_DELAY);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_RST;
			pattern_q <= PATTERN_RST;
			delay_q   <= DELAY_RST;
		end else if (wr_en) begin
			case (wr_idx)
				REG_SIZE:    size_q    <= pwdata[SIZE_W-1:0];
				REG_PATTERN: pattern_q <= pwdata[PAT_W-1:0];
				REG_DELAY:   delay_q   <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (wr_idx)
			REG_SIZE:    prdata = PDATA_W'(size_q);
			REG_PATTERN: prdata = pattern_q;
			REG_DELAY:   prdata = PDATA_W'(delay_q);
			default:     prdata = '0;
		endcase
	end

	// period length: zero taken as one, clamped to the maximum
	always_comb begin
		if (size_q == '0)
			size_clamped = SIZE_W'(1);
		else if (size_q > MAXP)
			size_clamped = MAXP;
		else
			size_clamped = size_q;
	end

	// masked pattern rotated right within the period; empty means all kept
	always_comb begin
		mask64 = (64'd1 << n_q) - 64'd1;
		p64    = {32'd0, pattern_q} & mask64;
		lshift = 7'(n_q) - 7'(r_q);
		rot64  = ((p64 >> r_q) | (p64 << lshift)) & mask64;
		if (rot64 == 64'd0)
			rot64 = mask64;
	end

	// setup sequencer: reduce delay mod period, rotate, left-align
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			r_q     <= '0;
			n_q     <= CW'(SIZE_RST);
			rot_q   <= '0;
			pat_q   <= '0;
		end else if (restart) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					n_q     <= CW'(size_clamped);
					r_q     <= delay_q;
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					if (SIZE_W'(r_q) >= SIZE_W'(n_q))
						r_q <= r_q - DELAY_W'(n_q);
					else
						state_q <= S_ROT;
				end
				S_ROT: begin
					rot_q   <= rot64[MAX_PERIOD-1:0];
					state_q <= S_ALIGN;
				end
				S_ALIGN: begin
					pat_q   <= rot_q << (CW'(MAX_PERIOD) - n_q);
					state_q <= S_IDLE;
				end
				S_IDLE: ;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign eff_pattern = pat_q;
	assign eff_size    = n_q;
	assign ctl.busy    = (state_q != S_IDLE);
	assign ctl.restart = restart;

endmodule

/* rtl/core/sdp_queue.sv */
// Input sample queue between the accepting front and the run generator.
module sdp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sdp_pkg::sample_t  push_sample,
	output logic              full,
	output logic              q_valid,
	output sdp_pkg::sample_t  q_sample,
	input  logic              q_pop
);
	import sdp_pkg::*;

	sample_t           entries_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign full     = (count_q == (Q_AW + 1)'(Q_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_sample = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	// sample storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_sample;
	end

endmodule

/* rtl/core/sdp_runner.sv */
// Run generator: walks the period and emits one symbol per cycle unless it is stalled.
module sdp_runner #(
	parameter int MAX_PERIOD = 32,
	localparam int CW = $clog2(MAX_PERIOD + 1),
	localparam int PW = $clog2(MAX_PERIOD)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MAX_PERIOD-1:0]  eff_pattern,
	input  logic [CW-1:0]          eff_size,
	input  sdp_pkg::sdp_ctl_t      ctl,
	input  logic                   q_valid,
	input  sdp_pkg::sample_t       q_sample,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sdp_pkg::sample_t       out_sample,
	output logic                   is_erasure,
	output logic                   last_of_run
);
	import sdp_pkg::*;

	localparam logic [PW-1:0] TOP_IDX = PW'(MAX_PERIOD - 1);

	logic [PW-1:0]  pos_q;
	logic [CW-1:0]  k_q;
	logic           trail_q;
	logic           out_valid_q;
	sample_t        sample_q;
	logic           erasure_q;
	logic           last_q;

	logic [CW-1:0]  npos;
	logic           kept_cur;
	logic           kept_next;
	logic           wrap_next;
	logic           emit_sample;
	logic           last;
	logic           fire;

	// position lookahead; pattern msb is position zero
	assign npos        = CW'(pos_q) + 1'b1;
	assign kept_cur    = eff_pattern[TOP_IDX - pos_q];
	assign kept_next   = eff_pattern[TOP_IDX - npos[PW-1:0]];
	assign wrap_next   = (npos >= eff_size);
	assign emit_sample = !trail_q && (kept_cur || (k_q >= eff_size - 1'b1));
	assign last        = (trail_q || emit_sample) &&
		(wrap_next || kept_next || (k_q + 1'b1 >= eff_size));
	assign fire        = q_valid && !ctl.busy && (!out_valid_q || out_ready);
	assign q_pop       = fire && last;

	// walk state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			k_q         <= '0;
			trail_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.restart) begin
				pos_q   <= '0;
				k_q     <= '0;
				trail_q <= 1'b0;
			end else if (fire) begin
				if (last) begin
					pos_q   <= wrap_next ? '0 : npos[PW-1:0];
					k_q     <= '0;
					trail_q <= 1'b0;
				end else if (emit_sample) begin
					pos_q   <= npos[PW-1:0];
					k_q     <= k_q + 1'b1;
					trail_q <= 1'b1;
				end else begin
					// leading hole, may wrap past the period end
					pos_q <= wrap_next ? '0 : npos[PW-1:0];
					k_q   <= k_q + 1'b1;
				end
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q  <= emit_sample ? q_sample : '0;
			erasure_q <= !emit_sample;
			last_q    <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = sample_q;
	assign is_erasure  = erasure_q;
	assign last_of_run = last_q;

	// position always within the current period
	a_pos_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) < eff_size)
		else $error("period position beyond period length");

	// a run never exceeds one period
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q < eff_size)
		else $error("run count reached period length");

	// trailing phase only ever sits on a hole
	a_trail_hole: assert property (@(posedge clk) disable iff (!arst_n)
		trail_q |-> !kept_cur)
		else $error("trailing phase on a kept position");

	// retiring a sample puts a flagged final symbol in the output register
	a_pop_flags_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid_q && last_q))
		else $error("sample retired without last_of_run");

endmodule

/* rtl/core/soft_symbol_depuncturer.sv */
// Top level of the soft symbol depuncturer.
// A sample passes the input queue and then the output register before its first symbol shows.
// Throughput: one output symbol per cycle from the run generator unless it stalls; a sample
// yields as many symbols as its run holds (1 to period length) and stays queued until its last.
// Reset and every write to a listed register restart the period and rebuild the pattern:
// in_ready stays low while the pattern is rebuilt; reset also loads the register reset values.
module soft_symbol_depuncturer #(
	parameter int MAX_PERIOD = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sdp_pkg::PADDR_W-1:0]  paddr,
	input  logic [sdp_pkg::PDATA_W-1:0]  pwdata,
	output logic [sdp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sdp_pkg::sample_t             soft_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output sdp_pkg::sample_t             out_sample,
	output logic                         is_erasure,
	output logic                         last_of_run
);
	import sdp_pkg::*;

	localparam int CW = $clog2(MAX_PERIOD + 1);

	logic [MAX_PERIOD-1:0] eff_pattern;
	logic [CW-1:0]         eff_size;
	sdp_ctl_t              ctl;
	logic                  q_full;
	logic                  q_valid;
	sample_t               q_sample;
	logic                  q_pop;
	logic                  push;

	assign pready   = 1'b1;
	assign in_ready = !q_full && !ctl.busy;
	assign push     = in_valid && in_ready;

	sdp_regs #(.MAX_PERIOD(MAX_PERIOD)) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.eff_pattern (eff_pattern),
		.eff_size    (eff_size),
		.ctl         (ctl)
	);

	sdp_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_sample (soft_sample),
		.full        (q_full),
		.q_valid     (q_valid),
		.q_sample    (q_sample),
		.q_pop       (q_pop)
	);

	sdp_runner #(.MAX_PERIOD(MAX_PERIOD)) u_runner (
		.clk         (clk),
		.arst_n      (arst_n),
		.eff_pattern (eff_pattern),
		.eff_size    (eff_size),
		.ctl         (ctl),
		.q_valid     (q_valid),
		.q_sample    (q_sample),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.is_erasure  (is_erasure),
		.last_of_run (last_of_run)
	);

endmodule
